// ----- rtl/work_range_splitter_defines.svh -----
// Assertion macros used by the work range splitter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef WORK_RANGE_SPLITTER_DEFINES_SVH
`define WORK_RANGE_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WRS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wrs_pkg.sv -----
// Package for the work range splitter: default sizes, register codes, state type.
// No dependencies.
package wrs_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int MAX_CHUNKS_DEF  = 64;
  localparam int MAX_THREADS_DEF = 16;

  localparam int OUT_WIDTH       = 32;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 8;
  localparam int THREAD_WIDTH    = 5;
  localparam int PER_THREAD_WIDTH = 3;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t CFG_THREAD_COUNT      = 2'd0;
  localparam cfg_index_t CFG_CHUNKS_PER_THREAD = 2'd1;

  localparam logic [THREAD_WIDTH-1:0]     THREAD_COUNT_RESET      = 5'd1;
  localparam logic [PER_THREAD_WIDTH-1:0] CHUNKS_PER_THREAD_RESET = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } wrs_state_t;

endpackage

// ----- rtl/wrs_divider.sv -----
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on wrs_pkg for the default dividend width.
module wrs_divider #(
  parameter int COUNT_WIDTH = wrs_pkg::COUNT_WIDTH_DEF,
  parameter int DIV_WIDTH   = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COUNT_WIDTH-1:0] dividend,
  input  logic [DIV_WIDTH-1:0]   divisor,
  output logic                   done,
  output logic [COUNT_WIDTH-1:0] quotient,
  output logic                   rem_nonzero
);

  localparam int CNT_WIDTH = $clog2(COUNT_WIDTH + 1);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] quo_r, quo_nxt;
  logic [DIV_WIDTH-1:0]   rem_r, rem_nxt;
  logic [DIV_WIDTH-1:0]   dvs_r, dvs_nxt;
  logic [DIV_WIDTH:0]     shifted;
  logic [DIV_WIDTH:0]     diff;
  logic                   fits;

  always_comb begin
    shifted  = {rem_r, quo_r[COUNT_WIDTH-1]};
    diff     = shifted - {1'b0, dvs_r};
    fits     = (shifted >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_WIDTH'(COUNT_WIDTH);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[COUNT_WIDTH-2:0], fits};
      rem_nxt = fits ? diff[DIV_WIDTH-1:0] : shifted[DIV_WIDTH-1:0];
      cnt_nxt = cnt_r - CNT_WIDTH'(1);
      if (cnt_r == CNT_WIDTH'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done        = done_r;
  assign quotient    = quo_r;
  assign rem_nonzero = (rem_r != '0);

endmodule

// ----- rtl/work_range_splitter.sv -----
// Top level of the work range splitter: control sequencer, range emitter, config registers.
// Depends on wrs_pkg, wrs_divider and work_range_splitter_defines.svh.
//
// Usage: a transaction on the command channel is accepted when start is high
// and busy is low; in_item_count gives the number of items N to partition.
// The block splits [0, N) into contiguous ranges, one result transaction per
// range on out_range_begin, out_range_end and out_last_range, each shown for
// exactly one cycle while out_valid is high. The receiver cannot stall, so
// results are produced at full rate, one per cycle, and last_range marks the
// final one. A count of zero is accepted and produces no results.
// After acceptance the bit-serial divider computes the chunk size, the
// sequencer rounds it up to the ceiling in the divide state, and the emit
// state then produces the k ranges of the item, with k at most MAX_CHUNKS.
// busy is high the whole time, so one item is worked on at a time and a
// new command is not accepted until the sequencer is idle again.
// The config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// thread count and chunks-per-thread registers; cfg_ready is always high and
// writes are expected only while the block is idle.
// Reset (synchronous, rst_n low) returns the sequencer to idle, drops
// out_valid, and sets thread count to 1 and chunks per thread to 4.
module work_range_splitter #(
  parameter int MAX_CHUNKS  = wrs_pkg::MAX_CHUNKS_DEF,
  parameter int MAX_THREADS = wrs_pkg::MAX_THREADS_DEF,
  parameter int COUNT_WIDTH = wrs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [COUNT_WIDTH-1:0]               in_item_count,
  // Result channel
  output logic                                 out_valid,
  output logic [wrs_pkg::OUT_WIDTH-1:0]        out_range_begin,
  output logic [wrs_pkg::OUT_WIDTH-1:0]        out_range_end,
  output logic                                 out_last_range,
  // Configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wrs_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [wrs_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  `include "work_range_splitter_defines.svh"

  // Divisor width: enough to hold MAX_CHUNKS itself.
  localparam int DIV_WIDTH = $clog2(MAX_CHUNKS + 1);
  localparam int PROD_WIDTH = wrs_pkg::THREAD_WIDTH + wrs_pkg::PER_THREAD_WIDTH;
  localparam logic [6:0] THREAD_LIMIT = 7'(MAX_THREADS);
  localparam logic [PROD_WIDTH-1:0] CHUNK_LIMIT = PROD_WIDTH'(MAX_CHUNKS);

  wrs_pkg::wrs_state_t state_r, state_nxt;

  logic [wrs_pkg::THREAD_WIDTH-1:0]     thread_count_r;
  logic [wrs_pkg::PER_THREAD_WIDTH-1:0] chunks_per_thread_r;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [COUNT_WIDTH-1:0] size_r, size_nxt;
  logic [COUNT_WIDTH-1:0] begin_r, begin_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [wrs_pkg::OUT_WIDTH-1:0] out_begin_r, out_begin_nxt;
  logic [wrs_pkg::OUT_WIDTH-1:0] out_end_r, out_end_nxt;
  logic                          out_last_r, out_last_nxt;

  // Chunk target from the configuration registers, clamped to MAX_CHUNKS and N.
  logic [wrs_pkg::THREAD_WIDTH-1:0]     eff_threads;
  logic [wrs_pkg::PER_THREAD_WIDTH-1:0] eff_per_thread;
  logic [PROD_WIDTH-1:0]                chunk_prod;
  logic [PROD_WIDTH-1:0]                chunk_capped;
  logic [DIV_WIDTH-1:0]                 chunks;

  // Range emitter datapath: one add and one compare per cycle.
  logic [COUNT_WIDTH:0]   next_sum;
  logic                   is_last;
  logic [COUNT_WIDTH-1:0] range_end;

  logic                   accept;
  logic                   div_start;
  logic                   div_done;
  logic [COUNT_WIDTH-1:0] div_quotient;
  logic                   div_rem_nonzero;

  assign accept = start && (state_r == wrs_pkg::ST_IDLE);

  always_comb begin
    if (thread_count_r == '0) begin
      eff_threads = wrs_pkg::THREAD_WIDTH'(1);
    end else if ({2'b00, thread_count_r} > THREAD_LIMIT) begin
      eff_threads = THREAD_LIMIT[wrs_pkg::THREAD_WIDTH-1:0];
    end else begin
      eff_threads = thread_count_r;
    end
    if (chunks_per_thread_r == '0) begin
      eff_per_thread = wrs_pkg::PER_THREAD_WIDTH'(1);
    end else begin
      eff_per_thread = chunks_per_thread_r;
    end
    chunk_prod   = PROD_WIDTH'(eff_threads) * PROD_WIDTH'(eff_per_thread);
    chunk_capped = (chunk_prod > CHUNK_LIMIT) ? CHUNK_LIMIT : chunk_prod;
    // A count smaller than the target caps the chunk number at the count.
    if (in_item_count < COUNT_WIDTH'(chunk_capped)) begin
      chunks = in_item_count[DIV_WIDTH-1:0];
    end else begin
      chunks = chunk_capped[DIV_WIDTH-1:0];
    end
  end

  always_comb begin
    next_sum  = {1'b0, begin_r} + {1'b0, size_r};
    is_last   = (next_sum >= {1'b0, count_r});
    range_end = is_last ? count_r : next_sum[COUNT_WIDTH-1:0];
  end

  // Sequencer: idle, wait for the divider, then emit one range per cycle.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    size_nxt      = size_r;
    begin_nxt     = begin_r;
    out_valid_nxt = 1'b0;
    out_begin_nxt = out_begin_r;
    out_end_nxt   = out_end_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    unique case (state_r)
      wrs_pkg::ST_IDLE: begin
        if (accept && (in_item_count != '0)) begin
          count_nxt = in_item_count;
          begin_nxt = '0;
          div_start = 1'b1;
          state_nxt = wrs_pkg::ST_DIVIDE;
        end
      end
      wrs_pkg::ST_DIVIDE: begin
        if (div_done) begin
          // Round the quotient up to get the ceiling chunk size.
          size_nxt  = div_quotient + COUNT_WIDTH'(div_rem_nonzero);
          state_nxt = wrs_pkg::ST_EMIT;
        end
      end
      wrs_pkg::ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_begin_nxt = wrs_pkg::OUT_WIDTH'(begin_r);
        out_end_nxt   = wrs_pkg::OUT_WIDTH'(range_end);
        out_last_nxt  = is_last;
        begin_nxt     = range_end;
        if (is_last) begin
          state_nxt = wrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r     <= count_nxt;
    size_r      <= size_nxt;
    begin_r     <= begin_nxt;
    out_begin_r <= out_begin_nxt;
    out_end_r   <= out_end_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Configuration registers; indexes outside the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thread_count_r      <= wrs_pkg::THREAD_COUNT_RESET;
      chunks_per_thread_r <= wrs_pkg::CHUNKS_PER_THREAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wrs_pkg::CFG_THREAD_COUNT: begin
          thread_count_r <= cfg_data[wrs_pkg::THREAD_WIDTH-1:0];
        end
        wrs_pkg::CFG_CHUNKS_PER_THREAD: begin
          chunks_per_thread_r <= cfg_data[wrs_pkg::PER_THREAD_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  wrs_divider #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .DIV_WIDTH   (DIV_WIDTH)
  ) u_divider (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .dividend    (in_item_count),
    .divisor     (chunks),
    .done        (div_done),
    .quotient    (div_quotient),
    .rem_nonzero (div_rem_nonzero)
  );

  assign busy            = (state_r != wrs_pkg::ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_range_begin = out_begin_r;
  assign out_range_end   = out_end_r;
  assign out_last_range  = out_last_r;

  // Every cycle in the emit state produces exactly one result next cycle.
  `WRS_ASSERT_NEXT(a_emit_gives_result, clk, rst_n,
    state_r == wrs_pkg::ST_EMIT, out_valid_r, "emit cycle produced no result")

  // A result that is not the last one leaves the block still emitting.
  `WRS_ASSERT_SAME(a_not_last_stays_busy, clk, rst_n,
    out_valid_r && !out_last_r, state_r == wrs_pkg::ST_EMIT,
    "non-final range but sequencer left emit")

  // Every emitted range starts below the count, so it is never empty.
  `WRS_ASSERT_SAME(a_begin_below_count, clk, rst_n,
    state_r == wrs_pkg::ST_EMIT, begin_r < count_r, "range begin reached count")

  // A zero count is taken without leaving idle.
  `WRS_ASSERT_NEXT(a_zero_count_idle, clk, rst_n,
    accept && (in_item_count == '0), !busy, "zero count did not stay idle")

  // The divider finishes only while the sequencer waits for it.
  `WRS_ASSERT_SAME(a_div_done_in_divide, clk, rst_n,
    div_done, state_r == wrs_pkg::ST_DIVIDE, "divider finished outside divide state")

endmodule
